### src/rid_pkg.sv
package rid_pkg;

  // widths of the fixed fields
  localparam int SPS_W   = 10;
  localparam int SLOTC_W = 5;
  localparam int SLOT_W  = 4;
  localparam int STEP_W  = 13;
  localparam int ALU_W   = 15;

  localparam logic [STEP_W-1:0] STEP_TOTAL_MAX = 13'h1FFF;

  // configuration register indexes
  localparam logic CFG_STEPS_PER_SLOT = 1'b0;
  localparam logic CFG_SLOT_COUNT     = 1'b1;

  // full-step coil patterns, A1,A2,B1,B2 on bits 3..0
  localparam logic [3:0] COIL_TABLE [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] target_slot;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        coil_pattern;
    logic              coils_driven;
    logic              moving;
    logic [SLOT_W-1:0] position_now;
    logic              rejected;
  } out_item_t;

  // settings handed from the register file to the core
  typedef struct packed {
    logic [SPS_W-1:0]   steps_per_slot;
    logic [SLOTC_W-1:0] slots;
  } cfg_t;

endpackage

### src/rid_alu.sv
module rid_alu (
  input  rid_pkg::alu_op_t           op,
  input  logic [rid_pkg::ALU_W-1:0]  a,
  input  logic [rid_pkg::ALU_W-1:0]  b,
  output logic [rid_pkg::ALU_W-1:0]  y
);
  import rid_pkg::*;

  // shared add / subtract
  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

### src/rid_core.sv
module rid_core (
  input  logic              clk,
  input  logic              rst_n,
  input  rid_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  rid_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output rid_pkg::out_item_t out_item
);
  import rid_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_FOLD = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // ring and motor state
  logic [SLOT_W-1:0] current_r, current_nxt;
  logic [SLOT_W-1:0] goal_r, goal_nxt;
  logic [STEP_W-1:0] total_r, total_nxt;
  logic [STEP_W-1:0] done_r, done_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              reverse_r, reverse_nxt;

  // move command working registers
  logic [SLOT_W-1:0] target_r, target_nxt;
  logic signed [5:0] v_r, v_nxt;
  logic [SLOT_W-1:0] mag_r, mag_nxt;
  logic              rev_r, rev_nxt;
  logic [1:0]        bit_r, bit_nxt;
  logic [ALU_W-1:0]  acc_r, acc_nxt;

  out_item_t res_r, res_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic [ALU_W-1:0] v_ext, n_ext, addend;
  logic [STEP_W-1:0] sat_total;
  logic             accept;

  rid_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign v_ext  = {{(ALU_W-6){v_r[5]}}, v_r};
  assign n_ext  = {{(ALU_W-SLOTC_W){1'b0}}, cfg.slots};
  assign addend = {{(ALU_W-SPS_W){1'b0}}, cfg.steps_per_slot} << bit_r;

  // saturated step total from the last partial product
  assign sat_total = (acc_nxt > {{(ALU_W-STEP_W){1'b0}}, STEP_TOTAL_MAX}) ?
                     STEP_TOTAL_MAX : acc_nxt[STEP_W-1:0];

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    current_nxt = current_r;
    goal_nxt    = goal_r;
    total_nxt   = total_r;
    done_nxt    = done_r;
    phase_nxt   = phase_r;
    reverse_nxt = reverse_r;
    target_nxt  = target_r;
    v_nxt       = v_r;
    mag_nxt     = mag_r;
    rev_nxt     = rev_r;
    bit_nxt     = bit_r;
    acc_nxt     = acc_r;
    res_nxt     = res_r;
    alu_op      = ALU_ADD;
    alu_a       = acc_r;
    alu_b       = addend;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (!in_item.operation) begin
            // timer tick
            if (done_r < total_r) begin
              res_nxt.coil_pattern = COIL_TABLE[phase_r];
              res_nxt.coils_driven = 1'b1;
              phase_nxt = reverse_r ? phase_r - 2'd1 : phase_r + 2'd1;
              done_nxt  = done_r + 1'b1;
              res_nxt.moving = (done_nxt < total_r);
              res_nxt.position_now = current_r;
            end else begin
              current_nxt = goal_r;
              res_nxt.moving = 1'b0;
              res_nxt.position_now = goal_r;
            end
            state_nxt = S_DONE;
          end else if ({1'b0, in_item.target_slot} >= cfg.slots) begin
            // target beyond the ring
            res_nxt.rejected     = 1'b1;
            res_nxt.moving       = (done_r < total_r);
            res_nxt.position_now = current_r;
            state_nxt = S_DONE;
          end else begin
            target_nxt = in_item.target_slot;
            v_nxt = $signed({2'b00, in_item.target_slot}) - $signed({2'b00, current_r});
            state_nxt = S_MOD;
          end
        end
      end

      // bring the raw distance into 0..n-1 one add or subtract at a time
      S_MOD: begin
        alu_a = v_ext;
        alu_b = n_ext;
        if (v_r[5]) begin
          alu_op = ALU_ADD;
          v_nxt  = alu_y[5:0];
        end else if (v_r[4:0] >= cfg.slots) begin
          alu_op = ALU_SUB;
          v_nxt  = alu_y[5:0];
        end else if (v_r[4:0] > (cfg.slots >> 1)) begin
          rev_nxt   = 1'b1;
          state_nxt = S_FOLD;
        end else begin
          mag_nxt   = v_r[SLOT_W-1:0];
          rev_nxt   = (v_r == 6'sd0);
          acc_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = S_MUL;
        end
      end

      // going backward: magnitude is n - d
      S_FOLD: begin
        alu_op    = ALU_SUB;
        alu_a     = n_ext;
        alu_b     = v_ext;
        mag_nxt   = alu_y[SLOT_W-1:0];
        acc_nxt   = '0;
        bit_nxt   = '0;
        state_nxt = S_MUL;
      end

      // shift-add multiply, one magnitude bit per cycle
      S_MUL: begin
        alu_op = ALU_ADD;
        if (mag_r[bit_r]) begin
          acc_nxt = alu_y;
        end
        bit_nxt = bit_r + 2'd1;
        if (bit_r == 2'(SLOT_W-1)) begin
          total_nxt   = sat_total;
          done_nxt    = '0;
          goal_nxt    = target_r;
          reverse_nxt = rev_r;
          res_nxt     = '0;
          res_nxt.moving       = (sat_total != '0);
          res_nxt.position_now = current_r;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  // control and ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      current_r   <= '0;
      goal_r      <= '0;
      total_r     <= '0;
      done_r      <= '0;
      phase_r     <= '0;
      reverse_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      current_r   <= current_nxt;
      goal_r      <= goal_nxt;
      total_r     <= total_nxt;
      done_r      <= done_nxt;
      phase_r     <= phase_nxt;
      reverse_r   <= reverse_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    v_r      <= v_nxt;
    mag_r    <= mag_nxt;
    rev_r    <= rev_nxt;
    bit_r    <= bit_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule

### src/rotary_indexer_stepper_drive.sv
// Rotary indexer stepper drive: full-step sequencer that turns a ring to one of
// slot_count slots. Each input item is a timer tick or a move command; each
// item gives exactly one result item on the out_ channel.
// Channels: in_valid/in_ready with in_item, out_valid/out_ready with out_item.
// Settings are to be written through cfg_we/cfg_index/cfg_wdata by the user only
// while the block is idle; the block itself does not enforce this. Index 0 is
// steps_per_slot, index 1 slot_count (clamped to 2..MAX_SLOTS, at most 31).
// A tick or a rejected move goes from the idle state through S_DONE to the
// result register. An accepted move passes through S_MOD, where the shared
// adder wraps the distance into the ring one add or subtract at a time, then
// S_FOLD only when the short way is backward past half the ring, then the
// shift-add multiply in S_MUL, one magnitude bit per cycle, then S_DONE.
// One item is in work at a time: in_ready is high only while the sequencer
// is idle, so a new item is taken only after the last result is registered.
// The result register holds one finished item; while out_ready is low the
// next result waits in the sequencer and in_ready stays low.
// Reset (rst_n low, synchronous) clears position, goal, step counters, phase
// and direction, and loads steps_per_slot = 25 and slot_count = 8.
module rotary_indexer_stepper_drive #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rid_pkg::SPS_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rid_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rid_pkg::out_item_t          out_item
);
  import rid_pkg::*;

  // a 5-bit count never exceeds 31, so the cap only matters below that
  localparam int NCAP = (MAX_SLOTS > 31) ? 31 : MAX_SLOTS;
  localparam logic [SLOTC_W-1:0] NCAP_W = NCAP[SLOTC_W-1:0];

  logic [SPS_W-1:0]   sps_r;
  logic [SLOTC_W-1:0] slot_count_r;
  logic [SLOTC_W-1:0] slots_eff;
  cfg_t               cfg;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r        <= 10'd25;
      slot_count_r <= 5'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEPS_PER_SLOT: sps_r        <= cfg_wdata;
        CFG_SLOT_COUNT:     slot_count_r <= cfg_wdata[SLOTC_W-1:0];
        default:            sps_r        <= sps_r;
      endcase
    end
  end

  // effective ring size
  always_comb begin
    priority if (slot_count_r < 5'd2) begin
      slots_eff = 5'd2;
    end else if (slot_count_r > NCAP_W) begin
      slots_eff = NCAP_W;
    end else begin
      slots_eff = slot_count_r;
    end
  end

  assign cfg.steps_per_slot = sps_r;
  assign cfg.slots          = slots_eff;

  rid_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### tb/rotary_indexer_stepper_drive_tb.sv
`timescale 1ns / 1ps

module rotary_indexer_stepper_drive_tb;
  import rid_pkg::*;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } drive_op_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  localparam int RING_MAX     = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 110;
  localparam int N_PHASES     = 10;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [SPS_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;

  // predictor copy of settings and drive state
  logic [SPS_W-1:0]   pred_sps;
  logic [SLOTC_W-1:0] pred_slots;
  logic [3:0]         cur_slot;
  logic [3:0]         goal_slot;
  logic [STEP_W-1:0]  step_total;
  logic [STEP_W-1:0]  steps_done;
  logic [1:0]         coil_phase;
  bit                 rev_dir;

  out_item_t drive_queue[$];
  dir_row_t  dir_rows[$];
  int        mismatch_count = 0;
  int        results_seen = 0;
  int        stall_cycles = 0;
  bit        no_idle = 1'b0;
  bit        long_hold_done = 1'b0;

  rotary_indexer_stepper_drive uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // full-step coil sequence A1,A2,B1,B2
  function automatic logic [3:0] coil_of(logic [1:0] ph);
    case (ph)
      2'd0: coil_of = 4'hA;
      2'd1: coil_of = 4'h6;
      2'd2: coil_of = 4'h5;
      default: coil_of = 4'h9;
    endcase
  endfunction

  function automatic int ring_slots();
    int n;
    n = int'(pred_slots);
    if (n < 2) n = 2;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

  // advance the drive by one item and return the output it should give
  function automatic out_item_t advance_indexer(in_item_t it);
    out_item_t r;
    int n;
    int d;
    int total;
    r = '0;
    if (it.operation == OP_MOVE) begin
      n = ring_slots();
      if (int'(it.target_slot) >= n) begin
        r.rejected = 1'b1;
      end else begin
        d = int'(it.target_slot) - int'(cur_slot) + n;
        d = ((d % n) + n) % n;
        if (d > n / 2) d = d - n;
        total = (d < 0 ? -d : d) * int'(pred_sps);
        if (total > 8191) total = 8191;
        step_total = total[STEP_W-1:0];
        steps_done = '0;
        goal_slot  = it.target_slot;
        rev_dir    = (d > 0) ? 1'b0 : 1'b1;
      end
    end else if (steps_done < step_total) begin
      r.coil_pattern = coil_of(coil_phase);
      r.coils_driven = 1'b1;
      coil_phase     = rev_dir ? coil_phase - 2'd1 : coil_phase + 2'd1;
      steps_done     = steps_done + 1'b1;
    end else begin
      cur_slot = goal_slot;
    end
    r.moving       = (steps_done < step_total);
    r.position_now = cur_slot;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_row(logic op, logic [3:0] tgt, bit typed, out_item_t want);
    dir_row_t row;
    row.item.operation   = op;
    row.item.target_slot = tgt;
    row.typed            = typed;
    row.want             = want;
    dir_rows.push_back(row);
  endfunction

  function automatic out_item_t mk_out(logic [3:0] pat, logic drv, logic mov,
                                       logic [3:0] pos, logic rej);
    out_item_t r;
    r.coil_pattern = pat;
    r.coils_driven = drv;
    r.moving       = mov;
    r.position_now = pos;
    r.rejected     = rej;
    return r;
  endfunction

  task automatic report_bad(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic cmp_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want)
      report_bad($sformatf("%s expected %h got %h", name, want, got));
  endtask

  // offer one item, wait for it to be taken, then record what it should give
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    out_item_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = advance_indexer(it);
    drive_queue.push_back(typed ? want : pred);
  endtask

  task automatic send_plain(logic op, logic [3:0] tgt);
    in_item_t it;
    it.operation   = op;
    it.target_slot = tgt;
    send_item(it, 1'b0, '0);
  endtask

  // let every result come back, then a few quiet cycles
  task automatic settle();
    in_valid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SPS_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_STEPS_PER_SLOT) pred_sps = data;
    else pred_slots = data[SLOTC_W-1:0];
  endtask

  // result side: check each item against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (drive_queue.size() == 0) begin
        report_bad($sformatf("result %h with no item pending", out_item));
      end else begin
        want = drive_queue.pop_front();
        cmp_field("coil_pattern", want.coil_pattern, out_item.coil_pattern);
        cmp_field("coils_driven", {3'b000, want.coils_driven}, {3'b000, out_item.coils_driven});
        cmp_field("moving", {3'b000, want.moving}, {3'b000, out_item.moving});
        cmp_field("position_now", want.position_now, out_item.position_now);
        cmp_field("rejected", {3'b000, want.rejected}, {3'b000, out_item.rejected});
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold so the block backs up
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // sender: directed rows, then random phases under changing settings
  initial begin
    logic [SPS_W-1:0]   sps_set [N_PHASES];
    logic [SLOTC_W-1:0] slot_set [N_PHASES];
    out_item_t idle0;
    int n, cnt, remain, sent;
    logic [3:0] tgt;

    sps_set  = '{10'd1, 10'd3, 10'd0, 10'd1023, 10'd2, 10'd5, 10'd1, 10'd4, 10'd7, 10'd1};
    slot_set = '{5'd16, 5'd3, 5'd5, 5'd16, 5'd31, 5'd2, 5'd0, 5'd1, 5'd17, 5'd12};

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_STEPS_PER_SLOT;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_item   = '0;

    pred_sps   = 10'd25;
    pred_slots = 5'd8;
    cur_slot   = '0;
    goal_slot  = '0;
    step_total = '0;
    steps_done = '0;
    coil_phase = '0;
    rev_dir    = 1'b0;

    idle0 = '0;
    // reset settings: 25 steps per slot, 8 slots
    add_row(OP_TICK, 4'd0,  1'b1, idle0);
    add_row(OP_MOVE, 4'd8,  1'b1, mk_out(4'h0, 1'b0, 1'b0, 4'd0, 1'b1));
    add_row(OP_MOVE, 4'd15, 1'b1, mk_out(4'h0, 1'b0, 1'b0, 4'd0, 1'b1));
    // zero distance counts as reverse with nothing to do
    add_row(OP_MOVE, 4'd0,  1'b1, idle0);
    add_row(OP_TICK, 4'd15, 1'b1, idle0);
    add_row(OP_MOVE, 4'd1,  1'b1, mk_out(4'h0, 1'b0, 1'b1, 4'd0, 1'b0));
    add_row(OP_TICK, 4'd0,  1'b1, mk_out(4'hA, 1'b1, 1'b1, 4'd0, 1'b0));
    add_row(OP_TICK, 4'd0,  1'b1, mk_out(4'h6, 1'b1, 1'b1, 4'd0, 1'b0));
    add_row(OP_TICK, 4'd0,  1'b1, mk_out(4'h5, 1'b1, 1'b1, 4'd0, 1'b0));
    add_row(OP_TICK, 4'd0,  1'b1, mk_out(4'h9, 1'b1, 1'b1, 4'd0, 1'b0));
    // one slot backward across the wrap
    add_row(OP_MOVE, 4'd7,  1'b1, mk_out(4'h0, 1'b0, 1'b1, 4'd0, 1'b0));
    add_row(OP_TICK, 4'd0,  1'b1, mk_out(4'hA, 1'b1, 1'b1, 4'd0, 1'b0));
    add_row(OP_TICK, 4'd0,  1'b1, mk_out(4'h9, 1'b1, 1'b1, 4'd0, 1'b0));
    // half-ring tie goes forward
    add_row(OP_MOVE, 4'd4,  1'b0, idle0);
    add_row(OP_TICK, 4'd3,  1'b0, idle0);
    add_row(OP_TICK, 4'd12, 1'b0, idle0);
    // rejected target mid-move leaves the move running
    add_row(OP_MOVE, 4'd12, 1'b1, mk_out(4'h0, 1'b0, 1'b1, 4'd0, 1'b1));
    add_row(OP_TICK, 4'd0,  1'b0, idle0);
    add_row(OP_MOVE, 4'd3,  1'b0, idle0);
    add_row(OP_TICK, 4'd0,  1'b0, idle0);
    add_row(OP_MOVE, 4'd6,  1'b0, idle0);
    add_row(OP_TICK, 4'd9,  1'b0, idle0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_STEPS_PER_SLOT, sps_set[p]);
      write_reg(CFG_SLOT_COUNT, {{(SPS_W-SLOTC_W){1'b0}}, slot_set[p]});
      no_idle = (p == 3 || p == 7);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = ring_slots();
        if ($urandom_range(0, 99) < 82) begin
          // move then a run of ticks, usually long enough to finish
          if ($urandom_range(0, 9) == 0) tgt = 4'($urandom_range(0, 15));
          else tgt = 4'($urandom_range(0, n - 1));
          send_plain(OP_MOVE, tgt);
          remain = int'(step_total) - int'(steps_done);
          if ($urandom_range(0, 3) != 0) cnt = remain + $urandom_range(1, 3);
          else cnt = $urandom_range(0, remain);
          if (cnt > 60) cnt = $urandom_range(20, 60);
          for (int k = 0; k < cnt; k++) send_plain(OP_TICK, 4'($urandom_range(0, 15)));
          sent += cnt + 1;
        end else begin
          // noise: any op, any target
          cnt = $urandom_range(1, 6);
          for (int k = 0; k < cnt; k++)
            send_plain(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
          sent += cnt;
        end
      end
      settle();
    end

    no_idle = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && drive_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
